[rtl/core/tbcc_pkg.sv]
// Touch button click classifier: shared types, register indexes and reset values.
// No dependencies; imported by every module of the block.
package tbcc_pkg;

	localparam int DBC_W        = 4;
	localparam int THR_W        = 16;
	localparam int KIND_W       = 3;
	localparam int CFG_ADDR_W   = 3;
	localparam int OUT_PADS     = 4;
	localparam int IN_TDATA_W   = 8;
	localparam int OUT_TDATA_W  = 16;

	localparam int DEF_NUM_PADS   = 4;
	localparam int DEF_HOLD_WIDTH = 16;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DEBOUNCE_LIMIT = 3'd0,
		REG_VSHORT_TICKS   = 3'd1,
		REG_SHORT_TICKS    = 3'd2,
		REG_LONG_TICKS     = 3'd3,
		REG_VLONG_TICKS    = 3'd4
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 3'd0,
		KIND_VSHORT = 3'd1,
		KIND_SHORT  = 3'd2,
		KIND_LONG   = 3'd3,
		KIND_VLONG  = 3'd4
	} click_kind_t;

	typedef struct packed {
		logic [DBC_W-1:0] debounce_limit;
		logic [THR_W-1:0] vshort_ticks;
		logic [THR_W-1:0] short_ticks;
		logic [THR_W-1:0] long_ticks;
		logic [THR_W-1:0] vlong_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		debounce_limit: 4'd10,
		vshort_ticks:   16'd5,
		short_ticks:    16'd20,
		long_ticks:     16'd100,
		vlong_ticks:    16'd300
	};

endpackage

[rtl/core/tbcc_pad.sv]
// Per-pad debounce, hold counter and click classification state.
// Depends on tbcc_pkg; instantiated once per pad by the top level.
module tbcc_pad #(
	parameter int HOLD_WIDTH = tbcc_pkg::DEF_HOLD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          active,
	input  logic                          hold_off,
	input  tbcc_pkg::cfg_t                cfg,
	output logic                          seen_nxt,
	output logic [tbcc_pkg::KIND_W-1:0]   kind_nxt
);
	import tbcc_pkg::*;

	localparam int CMP_W = (HOLD_WIDTH > THR_W) ? HOLD_WIDTH : THR_W;

	logic [DBC_W-1:0]      dbc_q, dbc_nxt;
	logic                  en_q, en_nxt;
	logic [HOLD_WIDTH-1:0] hold_q, hold_nxt;
	logic                  seen_q;
	logic [KIND_W-1:0]     kind_q;
	logic [DBC_W:0]        dbc_inc;
	logic [CMP_W-1:0]      hold_x;
	click_kind_t           match;

	assign dbc_inc = {1'b0, dbc_q} + {{DBC_W{1'b0}}, 1'b1};
	assign hold_x  = CMP_W'(hold_q);

	always_comb begin
		if (hold_x == CMP_W'(cfg.vlong_ticks))
			match = KIND_VLONG;
		else if (hold_x == CMP_W'(cfg.long_ticks))
			match = KIND_LONG;
		else if (hold_x == CMP_W'(cfg.short_ticks))
			match = KIND_SHORT;
		else if (hold_x == CMP_W'(cfg.vshort_ticks))
			match = KIND_VSHORT;
		else
			match = KIND_NONE;
	end

	always_comb begin
		en_nxt  = en_q;
		dbc_nxt = dbc_q;
		if (active) begin
			if (dbc_inc > {1'b0, cfg.debounce_limit}) begin
				en_nxt  = 1'b1;
				dbc_nxt = DBC_W'(1);
			end else begin
				dbc_nxt = dbc_inc[DBC_W-1:0];
			end
		end else begin
			en_nxt  = 1'b0;
			dbc_nxt = '0;
		end

		seen_nxt = seen_q;
		kind_nxt = kind_q;
		hold_nxt = hold_q;
		if (!hold_off) begin
			if (en_nxt) begin
				if (match != KIND_NONE) begin
					seen_nxt = 1'b1;
					kind_nxt = match;
				end
				if (hold_x < CMP_W'(cfg.vlong_ticks) && hold_q != '1)
					hold_nxt = hold_q + HOLD_WIDTH'(1);
			end else begin
				seen_nxt = 1'b0;
				hold_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbc_q  <= '0;
			en_q   <= 1'b0;
			hold_q <= '0;
			seen_q <= 1'b0;
			kind_q <= KIND_NONE;
		end else if (step) begin
			dbc_q  <= dbc_nxt;
			en_q   <= en_nxt;
			hold_q <= hold_nxt;
			seen_q <= seen_nxt;
			kind_q <= kind_nxt;
		end
	end

endmodule

[rtl/core/touch_button_click_classifier.sv]
// Channel   | Group                          | Payload
// ----------+--------------------------------+--------------------------------------
// tick in   | s_tvalid / s_tready / s_tdata  | [3:0] pads_active, [4] hold_off
// result    | m_tvalid / m_tready / m_tdata  | flags, plus, minus, heart, mode types
// config    | cfg_wr_en / cfg_addr / cfg_wdata | write-only, index 0..4
//
// One tick per cycle unless the result stalls; path: input register, then result register.
// The per-pad state updates in the same cycle the input stage moves into the result register.
// A stalled result holds; the input stage still takes one more tick behind it.
// Asynchronous active-low reset clears all pad state and loads default thresholds.
module touch_button_click_classifier #(
	parameter int NUM_PADS   = tbcc_pkg::DEF_NUM_PADS,
	parameter int HOLD_WIDTH = tbcc_pkg::DEF_HOLD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tbcc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [3:0] pads_active, [4] hold_off
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [tbcc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [3:0] click_flags, [6:4] plus_type,
	                                                       // [9:7] minus_type, [12:10] heart_type,
	                                                       // [15:13] mode_type
	input  logic                                cfg_wr_en,
	input  logic [tbcc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tbcc_pkg::THR_W-1:0]          cfg_wdata
);
	import tbcc_pkg::*;

	cfg_t                   cfg_q;
	logic                   valid_s1;
	logic [OUT_PADS-1:0]    pads_s1;
	logic                   hold_off_s1;
	logic                   advance;
	logic [NUM_PADS-1:0]    seen_nxt;
	logic [KIND_W-1:0]      kind_nxt [NUM_PADS];
	logic [OUT_TDATA_W-1:0] result;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= cfg_wdata[DBC_W-1:0];
				REG_VSHORT_TICKS:   cfg_q.vshort_ticks   <= cfg_wdata;
				REG_SHORT_TICKS:    cfg_q.short_ticks    <= cfg_wdata;
				REG_LONG_TICKS:     cfg_q.long_ticks     <= cfg_wdata;
				REG_VLONG_TICKS:    cfg_q.vlong_ticks    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pads_s1     <= s_tdata[OUT_PADS-1:0];
			hold_off_s1 <= s_tdata[OUT_PADS];
		end
	end

	for (genvar p = 0; p < NUM_PADS; p++) begin : g_pad
		logic active;
		if (p < OUT_PADS) begin : g_in
			assign active = pads_s1[p];
		end else begin : g_idle
			assign active = 1'b0;
		end
		tbcc_pad #(
			.HOLD_WIDTH(HOLD_WIDTH)
		) u_pad (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (advance),
			.active   (active),
			.hold_off (hold_off_s1),
			.cfg      (cfg_q),
			.seen_nxt (seen_nxt[p]),
			.kind_nxt (kind_nxt[p])
		);
	end

	always_comb begin
		result = '0;
		for (int i = 0; i < OUT_PADS; i++) begin
			if (i < NUM_PADS) begin
				result[i] = seen_nxt[i];
				result[OUT_PADS + KIND_W*i +: KIND_W] = kind_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			m_tdata_q <= result;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/core/tbcc_checker.sv]
// Port-level checks for the touch button click classifier, bound to the top level.
// Depends on tbcc_pkg for field widths.
module tbcc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [tbcc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [tbcc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import tbcc_pkg::*;

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// input only back-pressured when a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting result");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:4] <= KIND_VLONG && m_tdata[9:7] <= KIND_VLONG &&
		             m_tdata[12:10] <= KIND_VLONG && m_tdata[15:13] <= KIND_VLONG)
		else $error("click type out of range");

	// a set flag always carries a click type
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[0] || m_tdata[6:4] != KIND_NONE) &&
		             (!m_tdata[1] || m_tdata[9:7] != KIND_NONE) &&
		             (!m_tdata[2] || m_tdata[12:10] != KIND_NONE) &&
		             (!m_tdata[3] || m_tdata[15:13] != KIND_NONE))
		else $error("click flag without click type");

endmodule

bind touch_button_click_classifier tbcc_checker u_tbcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
